// ===== sv/csle_pkg.sv =====
// Shared types and codes for the cursor sequence list engine.
// Holds the action and status codes and the command and status bundles
// passed between the controller and the datapath. Depends on nothing.
package csle_pkg;

	// Widths of the fixed item fields.
	localparam int ACT_W = 3;
	localparam int STS_W = 2;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_START   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ATTACH  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd4;

	// Result status codes.
	localparam logic [STS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STS_W-1:0] ST_NO_ITEM = 2'd1;
	localparam logic [STS_W-1:0] ST_FULL    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic s2;
		logic s3;
		logic s4;
		logic finish;
	} csle_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             err;
	} csle_sts_t;

endpackage

// ===== sv/csle_ctrl.sv =====
// Controller for the cursor sequence list engine.
// Sequences each action through its memory read and write steps and owns
// the handshake state. Depends on csle_pkg.
module csle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  csle_pkg::csle_sts_t sts,
	output csle_pkg::csle_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STEP2 = 3'd1;
	localparam logic [2:0] S_STEP3 = 3'd2;
	localparam logic [2:0] S_STEP4 = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// A new item is taken only between operations.
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.s2     = (state_q == S_STEP2);
		cmd.s3     = (state_q == S_STEP3);
		cmd.s4     = (state_q == S_STEP4);
		cmd.finish = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	// Next state. Errors and single-read actions skip the later steps.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_STEP2;
			end
			S_STEP2: begin
				if (sts.err) begin
					state_d = S_DONE;
				end else if (sts.act inside {csle_pkg::ACT_ADVANCE, csle_pkg::ACT_REMOVE,
						csle_pkg::ACT_INSERT, csle_pkg::ACT_ATTACH}) begin
					state_d = S_STEP3;
				end else begin
					state_d = S_DONE;
				end
			end
			S_STEP3: begin
				state_d = (sts.act == csle_pkg::ACT_ATTACH) ? S_STEP4 : S_DONE;
			end
			S_STEP4: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (cmd.finish) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output beat valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/csle_dpath.sv =====
// Datapath for the cursor sequence list engine.
// Holds the node value and link memories, the list pointers, the free
// chain and the result register. Depends on csle_pkg.
module csle_dpath #(
	parameter int CAPACITY = 64,
	parameter int DATA_W   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csle_pkg::csle_cmd_t cmd,
	output csle_pkg::csle_sts_t sts,
	input  logic [2:0]          action,
	input  logic [31:0]         entry_value,
	output logic [1:0]          status,
	output logic                has_item,
	output logic [31:0]         current_value,
	output logic [6:0]          item_count
);

	localparam int IDX_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] NONE = IDX_W'(CAPACITY);

	// Node memories.
	logic [IDX_W-1:0]  link_mem [CAPACITY];
	logic [DATA_W-1:0] val_mem  [CAPACITY];
	logic [IDX_W-1:0]  link_rd_q;
	logic [DATA_W-1:0] val_rd_q;

	// List state.
	logic [IDX_W-1:0] head_q, cur_q, bef_q, free_q, fresh_q, cnt_q;
	logic [IDX_W-1:0] node_q, nxt_q, x_q;
	logic             attach2_q;
	logic [2:0]       act_q;
	logic [DATA_W-1:0] val_q, cur_val_q;
	logic [1:0]       status_q;

	// Result register.
	logic [1:0]  out_status_q;
	logic        out_has_q;
	logic [31:0] out_value_q;
	logic [6:0]  out_count_q;

	logic             head_v, cur_v, bef_v, free_v;
	logic             err_no_item, err_full, err;
	logic             front, rm_head;
	logic [IDX_W-1:0] new_node;
	logic [IDX_W-1:0] rd_idx;
	logic             link_we, val_we;
	logic [IDX_W-1:0] link_wi, link_wd, val_wi;

	// Pointer checks and error detection on the held state.
	always_comb begin
		head_v      = head_q < NONE;
		cur_v       = cur_q < NONE;
		bef_v       = bef_q < NONE;
		free_v      = free_q < NONE;
		err_no_item = (act_q == csle_pkg::ACT_ADVANCE || act_q == csle_pkg::ACT_REMOVE)
			&& !cur_v;
		err_full    = (act_q == csle_pkg::ACT_INSERT || act_q == csle_pkg::ACT_ATTACH)
			&& ((cnt_q >= NONE) || (!free_v && fresh_q >= NONE));
		err         = err_no_item || err_full;
		front       = !head_v || !cur_v || !bef_v;
		rm_head     = (cur_q == head_q) || !bef_v;
		new_node    = free_v ? free_q : fresh_q;
		sts.act     = act_q;
		sts.err     = err;
	end

	// Read address: the first read follows the incoming action; the second follows
	// the data of the first for advance and remove, else the cursor, or for attach without one the node before it.
	always_comb begin
		rd_idx = cur_q;
		if (cmd.accept) begin
			case (action)
				csle_pkg::ACT_ADVANCE, csle_pkg::ACT_REMOVE: rd_idx = cur_q;
				csle_pkg::ACT_INSERT, csle_pkg::ACT_ATTACH:  rd_idx = free_q;
				default:                                       rd_idx = head_q;
			endcase
		end else if (cmd.s2) begin
			case (act_q)
				csle_pkg::ACT_ADVANCE, csle_pkg::ACT_REMOVE: rd_idx = link_rd_q;
				csle_pkg::ACT_ATTACH: rd_idx = cur_v ? cur_q : bef_q;
				default:              rd_idx = cur_q;
			endcase
		end
	end

	// Memory write selection for each step.
	always_comb begin
		link_we = 1'b0;
		link_wi = cur_q;
		link_wd = free_q;
		val_we  = 1'b0;
		val_wi  = new_node;
		if (cmd.s2 && !err) begin
			case (act_q)
				csle_pkg::ACT_REMOVE: begin
					link_we = 1'b1;
					link_wi = cur_q;
					link_wd = free_q;
				end
				csle_pkg::ACT_INSERT: begin
					link_we = 1'b1;
					link_wi = new_node;
					link_wd = front ? head_q : cur_q;
					val_we  = 1'b1;
				end
				csle_pkg::ACT_ATTACH: begin
					val_we = 1'b1;
				end
				default: begin
					link_we = 1'b0;
				end
			endcase
		end else if (cmd.s3) begin
			case (act_q)
				csle_pkg::ACT_REMOVE: begin
					link_we = !rm_head;
					link_wi = bef_q;
					link_wd = nxt_q;
				end
				csle_pkg::ACT_INSERT: begin
					link_we = !front;
					link_wi = bef_q;
					link_wd = node_q;
				end
				csle_pkg::ACT_ATTACH: begin
					link_we = 1'b1;
					link_wi = node_q;
					if (!head_v) begin
						link_wd = NONE;
					end else if (!cur_v && !bef_v) begin
						link_wd = head_q;
					end else begin
						link_wd = link_rd_q;
					end
				end
				default: begin
					link_we = 1'b0;
				end
			endcase
		end else if (cmd.s4) begin
			link_we = attach2_q;
			link_wi = x_q;
			link_wd = node_q;
		end
	end

	// Node memories with registered read data.
	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wi[ADDR_W-1:0]] <= link_wd;
		if (val_we) val_mem[val_wi[ADDR_W-1:0]] <= val_q;
		link_rd_q <= link_mem[rd_idx[ADDR_W-1:0]];
		val_rd_q  <= val_mem[rd_idx[ADDR_W-1:0]];
	end

	// List pointers, free chain and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NONE;
			cur_q   <= NONE;
			bef_q   <= NONE;
			free_q  <= NONE;
			fresh_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.s2 && !err) begin
			case (act_q)
				csle_pkg::ACT_START: begin
					cur_q <= head_q;
					bef_q <= NONE;
				end
				csle_pkg::ACT_REMOVE: begin
					free_q <= cur_q;
				end
				csle_pkg::ACT_INSERT, csle_pkg::ACT_ATTACH: begin
					if (free_v) begin
						free_q <= link_rd_q;
					end else begin
						fresh_q <= fresh_q + IDX_W'(1);
					end
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase
		end else if (cmd.s3) begin
			case (act_q)
				csle_pkg::ACT_ADVANCE: begin
					bef_q <= cur_q;
					cur_q <= nxt_q;
				end
				csle_pkg::ACT_REMOVE: begin
					if (rm_head) head_q <= nxt_q;
					cur_q <= nxt_q;
					if (cnt_q != '0) cnt_q <= cnt_q - IDX_W'(1);
				end
				csle_pkg::ACT_INSERT: begin
					if (front) begin
						head_q <= node_q;
						bef_q  <= NONE;
					end
					cur_q <= node_q;
					cnt_q <= cnt_q + IDX_W'(1);
				end
				csle_pkg::ACT_ATTACH: begin
					if (!head_v) begin
						head_q <= node_q;
						bef_q  <= NONE;
					end else if (cur_v) begin
						bef_q <= cur_q;
					end else if (!bef_v) begin
						head_q <= node_q;
					end
					cur_q <= node_q;
					cnt_q <= cnt_q + IDX_W'(1);
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= action;
			val_q <= DATA_W'(entry_value);
		end
		if (cmd.s2) begin
			status_q <= err_no_item ? csle_pkg::ST_NO_ITEM :
				(err_full ? csle_pkg::ST_FULL : csle_pkg::ST_DONE);
			node_q   <= new_node;
			nxt_q    <= link_rd_q;
			x_q      <= cur_v ? cur_q : bef_q;
			if (act_q == csle_pkg::ACT_START) cur_val_q <= val_rd_q;
		end
		if (cmd.s3) begin
			attach2_q <= head_v && (cur_v || bef_v);
			case (act_q)
				csle_pkg::ACT_ADVANCE, csle_pkg::ACT_REMOVE: cur_val_q <= val_rd_q;
				csle_pkg::ACT_INSERT, csle_pkg::ACT_ATTACH:  cur_val_q <= val_q;
				default:                                       cur_val_q <= cur_val_q;
			endcase
		end
		if (cmd.finish) begin
			out_status_q <= status_q;
			out_has_q    <= cur_v;
			out_value_q  <= cur_v ? 32'(cur_val_q) : '0;
			out_count_q  <= 7'(cnt_q);
		end
	end

	assign status        = out_status_q;
	assign has_item      = out_has_q;
	assign current_value = out_value_q;
	assign item_count    = out_count_q;

endmodule

// ===== sv/cursor_sequence_list_engine.sv =====
// Cursor sequence list engine: ordered list of values with one cursor.
// Input channel (in_valid, in_stall, action, entry_value) takes one action
// per beat: start, advance, insert before cursor, attach after cursor or
// remove current. Output channel (out_valid, out_stall, status, has_item,
// current_value, item_count) returns exactly one result beat per action.
// Entries live in a singly linked list in node value and link memories
// (one read and one write port each, registered read data).
// Start, unknown actions and rejected actions pass through STEP2 to DONE;
// advance, insert and remove also pass STEP3, and attach STEP3 and STEP4.
// A new action is accepted only once the last has finished. The steps are
// set by the dependent link reads and link rewrites through the memory ports.
// The input is stalled while an action is being worked on; a finished
// result sits in an output register, so the next action is taken while it
// waits. If the receiver stalls, the result holds and the following action
// waits in its last step until the output register frees up.
// Reset clears the list to empty with no cursor; no clearing pass is
// needed, since data read from unwritten node memory is never used.
// Depends on csle_pkg, csle_ctrl and csle_dpath.
module cursor_sequence_list_engine #(
	parameter int CAPACITY = 64,
	parameter int DATA_W   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        has_item,
	output logic [31:0] current_value,
	output logic [6:0]  item_count
);

	csle_pkg::csle_cmd_t cmd;
	csle_pkg::csle_sts_t sts;

	// Sequencer.
	csle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// List storage and pointers.
	csle_dpath #(
		.CAPACITY (CAPACITY),
		.DATA_W   (DATA_W)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.entry_value   (entry_value),
		.status        (status),
		.has_item      (has_item),
		.current_value (current_value),
		.item_count    (item_count)
	);

	// An accepted beat blocks the input until the action completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accepted beat");

	// No current item means a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_item |-> current_value == '0)
		else $error("value reported without a current item");

	// Only defined status codes are reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == csle_pkg::ST_DONE || status == csle_pkg::ST_NO_ITEM ||
			status == csle_pkg::ST_FULL))
		else $error("undefined status code on a result beat");

	// A rejected remove or advance never reports a current item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == csle_pkg::ST_NO_ITEM |-> !has_item)
		else $error("no-item status with a current item");

endmodule
